// ----- sv/dqdf_pkg.sv -----
package dqdf_pkg;

  localparam int MaxEntries = 256;
  localparam int NameLimit  = 256;
  localparam int MaxPacket  = 1024;
  localparam int HdrLen     = 12;
  localparam int EntryW     = 8;
  localparam int NameW      = 8;
  localparam int PosW       = 11;
  localparam int HdrW       = 4;

  localparam logic [1:0] VerdictAllow = 2'd0;
  localparam logic [1:0] VerdictDeny  = 2'd1;
  localparam logic [1:0] VerdictBad   = 2'd2;

  localparam logic CmdEntry  = 1'b0;
  localparam logic CmdPacket = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LEN    = 2'd1,
    PH_LABEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    MS_IDLE  = 3'd0,
    MS_LEN   = 3'd1,
    MS_CHAR  = 3'd2,
    MS_NEXT  = 3'd3,
    MS_EMIT  = 3'd4,
    MS_HDR   = 3'd5
  } match_state_t;

  // A finished packet handed from the parser to the matcher.
  typedef struct packed {
    logic       bad;
    logic [8:0] name_len;
  } job_t;

  // Header byte rewrite for the NXDOMAIN response.
  function automatic logic [7:0] hdr_rewrite(input logic [HdrW-1:0] k, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (k == HdrW'(2)) r = b | 8'h80;
    else if (k == HdrW'(3)) r = (b & 8'hF0) | 8'h03;
    else if (k == HdrW'(6) || k == HdrW'(7)) r = 8'h00;
    return r;
  endfunction

endpackage

// ----- sv/dqdf_parser.sv -----
module dqdf_parser import dqdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  command,
  input  logic [7:0]            value,
  input  logic                  last,
  // Name buffer and header write ports.
  output logic                  name_we,
  output logic [NameW-1:0]      name_waddr,
  output logic [7:0]            name_wdata,
  output logic                  hdr_we,
  output logic [HdrW-1:0]       hdr_waddr,
  // Job handoff to the matcher (one-deep queue).
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);

  phase_t       phase, phase_next;
  logic [PosW-1:0] byte_position;
  logic [8:0]   name_length, name_length_next;
  logic [7:0]   label_remaining, label_remaining_next;
  logic         bad_packet, bad_next;
  logic         pkt_acc;
  logic         appending;
  logic [7:0]   append_char;

  // Requests stall while a finished job waits or the matcher is walking one,
  // because the walk reads the name, header and entry stores.
  assign in_ready = !job_valid && job_ready;
  assign pkt_acc  = in_valid && in_ready && (command == CmdPacket);

  // Parse one byte.
  always_comb begin
    phase_next = phase;
    name_length_next = name_length;
    label_remaining_next = label_remaining;
    bad_next = bad_packet;
    appending = 1'b0;
    append_char = value;
    hdr_we = 1'b0;
    if (byte_position >= PosW'(MaxPacket)) begin
      bad_next = 1'b1;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          hdr_we = pkt_acc && (byte_position < PosW'(HdrLen));
          if (byte_position >= PosW'(HdrLen - 1)) phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (value == 8'd0) begin
            if (name_length == 9'd0) bad_next = 1'b1;
            phase_next = PH_DONE;
          end else begin
            appending = (name_length != 9'd0);
            append_char = 8'h2E;
            label_remaining_next = value;
            phase_next = PH_LABEL;
          end
        end
        PH_LABEL: begin
          appending = 1'b1;
          if (label_remaining <= 8'd1) phase_next = PH_LEN;
          if (label_remaining > 8'd0) label_remaining_next = label_remaining - 8'd1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
    if (appending) begin
      if (name_length < 9'(NameLimit - 1)) name_length_next = name_length + 9'd1;
      else bad_next = 1'b1;
    end
  end

  assign name_we    = pkt_acc && appending && (name_length < 9'(NameLimit - 1));
  assign name_waddr = name_length[NameW-1:0];
  assign name_wdata = append_char;
  assign hdr_waddr  = byte_position[HdrW-1:0];

  // Parser state and job register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
      name_length <= '0;
      label_remaining <= '0;
      bad_packet <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (pkt_acc) begin
        if (last) begin
          job_valid <= 1'b1;
          job.bad <= bad_next || (phase_next != PH_DONE);
          job.name_len <= name_length_next;
          phase <= PH_HEADER;
          byte_position <= '0;
          name_length <= '0;
          label_remaining <= '0;
          bad_packet <= 1'b0;
        end else begin
          phase <= phase_next;
          if (byte_position < PosW'(MaxPacket)) byte_position <= byte_position + PosW'(1);
          name_length <= name_length_next;
          label_remaining <= label_remaining_next;
          bad_packet <= bad_next;
        end
      end
    end
  end

endmodule

// ----- sv/dqdf_matcher.sv -----
module dqdf_matcher import dqdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [8:0]            deny_count,
  // Entry writes.
  input  logic                  ent_we,
  input  logic [EntryW-1:0]     ent_idx,
  input  logic [7:0]            ent_pos,
  input  logic [7:0]            ent_char,
  input  logic                  ent_last,
  // Name and header writes from the parser.
  input  logic                  name_we,
  input  logic [NameW-1:0]      name_waddr,
  input  logic [7:0]            name_wdata,
  input  logic                  hdr_we,
  input  logic [HdrW-1:0]       hdr_waddr,
  input  logic [7:0]            hdr_wdata,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  job_t                  job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [1:0]            verdict,
  output logic [7:0]            data,
  output logic                  end_of_run
);

  logic [7:0] chars_mem [MaxEntries*256];
  logic [7:0] len_mem   [MaxEntries];
  logic [7:0] name_mem  [NameLimit];
  logic [7:0] hdr_mem   [HdrLen];

  match_state_t state, state_next;
  logic [8:0]   entry, limit;
  logic [8:0]   cpos;
  logic [8:0]   name_len;
  logic [1:0]   result;
  logic [HdrW-1:0] hk;
  logic [7:0]   len_q, char_q, name_q;
  logic         out_free;
  logic         out_load;

  assign limit    = (deny_count > 9'(MaxEntries)) ? 9'(MaxEntries) : deny_count;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state == MS_EMIT || state == MS_HDR);
  assign job_ready = (state == MS_IDLE);

  // Storage, with registered reads of the length, character and name stores.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      chars_mem[{ent_idx, ent_pos}] <= ent_char;
      if (ent_last) len_mem[ent_idx] <= ent_pos + 8'd1;
    end
    if (name_we) name_mem[name_waddr] <= name_wdata;
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    len_q  <= len_mem[entry[EntryW-1:0]];
    char_q <= chars_mem[{entry[EntryW-1:0], cpos[7:0]}];
    name_q <= name_mem[cpos[NameW-1:0]];
  end

  // Next state of the entry walk.
  always_comb begin
    state_next = state;
    unique case (state)
      MS_IDLE: if (job_valid) begin
        if (job.bad || limit == 9'd0) state_next = MS_EMIT;
        else state_next = MS_LEN;
      end
      MS_LEN: begin
        if ({1'b0, len_q} != name_len) state_next = MS_NEXT;
        else if (name_len == 9'd0) state_next = MS_EMIT;
        else state_next = MS_CHAR;
      end
      MS_CHAR: begin
        if (char_q != name_q) state_next = MS_NEXT;
        else if (cpos == name_len) state_next = MS_EMIT;
      end
      MS_NEXT: state_next = (entry >= limit) ? MS_EMIT : MS_LEN;
      MS_EMIT: if (out_free) state_next = (result == VerdictDeny) ? MS_HDR : MS_IDLE;
      MS_HDR: if (out_free && hk == HdrW'(HdrLen - 1)) state_next = MS_IDLE;
      default: state_next = MS_IDLE;
    endcase
  end

  // Walk counters and output register. Reads are registered and issued ahead, so
  // the entry counter already points at entry 0 while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      out_valid <= 1'b0;
      entry <= '0;
      cpos <= '0;
      hk <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        MS_IDLE: if (job_valid) begin
          name_len <= job.name_len;
          result <= job.bad ? VerdictBad : VerdictAllow;
          entry <= '0;
          cpos <= '0;
        end
        MS_LEN: begin
          cpos <= 9'd1;
          if ({1'b0, len_q} == name_len && name_len == 9'd0) result <= VerdictDeny;
        end
        MS_CHAR: begin
          if (char_q == name_q && cpos == name_len) result <= VerdictDeny;
          cpos <= cpos + 9'd1;
        end
        MS_NEXT: begin
          cpos <= '0;
        end
        MS_EMIT: begin
          entry <= '0;
          if (out_free) begin
            kind <= 1'b0;
            verdict <= result;
            data <= 8'd0;
            end_of_run <= (result != VerdictDeny);
            hk <= '0;
          end
        end
        MS_HDR: if (out_free) begin
          kind <= 1'b1;
          verdict <= VerdictDeny;
          data <= hdr_rewrite(hk, hdr_mem[hk]);
          end_of_run <= (hk == HdrW'(HdrLen - 1));
          hk <= hk + HdrW'(1);
        end
        default: begin
        end
      endcase
      // Advance to the next entry when leaving a mismatch.
      if ((state == MS_LEN || state == MS_CHAR) && state_next == MS_NEXT)
        entry <= entry + 9'd1;
    end
  end

endmodule

// ----- sv/dns_query_denylist_filter.sv -----
// DNS query deny-list filter.
// Requests enter on in_valid/in_ready with command, entry_index, char_pos,
// value and last. Command 0 writes one deny-list character (none at
// char_pos 255) and yields nothing. Command 1 is a packet byte, taken one
// per cycle while the matcher is idle and no job waits. On the last byte
// the finished name goes to the matcher through a one-deep job register,
// and in_ready stays low until the last result of that packet has been
// loaded into the output register. The verdict follows the job register
// and the entry walk: each counted entry has its length and, if equal,
// its characters compared, until one matches or the counted entries run
// out. On a deny, 12 response header results follow, one per cycle unless
// the receiver stalls. in_ready returns the cycle after the final result
// loads. Results leave on out_valid/out_ready from one output register; a
// stalled receiver holds the walk at its output step and the input stays
// stalled. Synchronous active-high rst clears the parser, the walk and the
// output valid; entry memories keep their contents. deny_count resets to 0.
module dns_query_denylist_filter import dqdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] entry_index,
  input  logic [7:0] char_pos,
  input  logic [7:0] value,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [1:0] verdict,
  output logic [7:0] data,
  output logic       end_of_run
);

  logic [8:0]      deny_count;
  logic            name_we, hdr_we, job_valid, job_ready, ent_we;
  logic [NameW-1:0] name_waddr;
  logic [7:0]      name_wdata;
  logic [HdrW-1:0] hdr_waddr;
  job_t            job;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) deny_count <= '0;
    else if (cfg_we) deny_count <= cfg_wdata;
  end

  assign ent_we = in_valid && in_ready && (command == CmdEntry) && (char_pos != 8'hFF);

  dqdf_parser u_parser (
    .clk, .rst, .in_valid, .in_ready, .command, .value, .last,
    .name_we, .name_waddr, .name_wdata, .hdr_we, .hdr_waddr,
    .job_valid, .job_ready, .job
  );

  dqdf_matcher u_matcher (
    .clk, .rst, .deny_count,
    .ent_we, .ent_idx(entry_index), .ent_pos(char_pos), .ent_char(value),
    .ent_last(last),
    .name_we, .name_waddr, .name_wdata, .hdr_we, .hdr_waddr, .hdr_wdata(value),
    .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .kind, .verdict, .data, .end_of_run
  );

endmodule

// ----- sv/dqdf_checker.sv -----
module dqdf_checker import dqdf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [1:0] verdict,
  input logic [7:0] data,
  input logic       end_of_run
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(kind))
    else $error("stalled result changed");

  // Verdict items carry zero data.
  a_vdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> data == 8'd0)
    else $error("verdict item with data");

  // Header bytes appear only for a deny.
  a_hdeny: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> verdict == VerdictDeny)
    else $error("header byte without deny");

  // A non-deny verdict closes its run.
  a_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && verdict != VerdictDeny |-> end_of_run)
    else $error("verdict without end of run");

endmodule

bind dns_query_denylist_filter dqdf_checker u_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dqdf_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic       kind;
    logic [1:0] verdict;
    logic [7:0] data;
    logic       eor;
  } result_t;

  typedef enum int {
    SH_NAME, SH_FLIP, SH_TRAIL, SH_SHORT, SH_HDRONLY, SH_ZERO, SH_UNTERM,
    SH_LONGNAME, SH_LONGPKT, SH_PTR, SH_ENT255, SH_CFG
  } shape_e;

  typedef struct {
    shape_e     shape;
    int         arg;
    bit         typed;
    logic [1:0] want;
  } row_t;

  logic       clk, rst;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  logic       in_valid, in_ready;
  logic       command;
  logic [7:0] entry_index, char_pos, value;
  logic       last;
  logic       out_valid, out_ready;
  logic       kind;
  logic [1:0] verdict;
  logic [7:0] data;
  logic       end_of_run;

  dns_query_denylist_filter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .entry_index(entry_index), .char_pos(char_pos), .value(value), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .verdict(verdict),
    .data(data), .end_of_run(end_of_run)
  );

  // Shadow copy of the block's state.
  logic [7:0] list_chars [MaxEntries][256];
  logic [8:0] list_len [MaxEntries];
  logic [7:0] hdr_copy [HdrLen];
  logic [7:0] name_buf [NameLimit];
  int         name_len, byte_pos, label_left;
  phase_t     phase;
  bit         pkt_bad;
  logic [8:0] deny_count;

  result_t    pending_results[$];
  bit         verdict_forced;
  logic [1:0] forced_verdict;

  // Entry texts as loaded, used to build matching queries.
  byte        entry_text [MaxEntries][$];

  int  errors, items_sent, pkts_sent, n_allow, n_deny, n_bad, results_seen;
  bit  quiet, hold_req, accepted_in;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fold one accepted request into the shadow state and queue its results.
  function automatic void predict_request(logic c, logic [7:0] e, logic [7:0] p,
                                          logic [7:0] v, logic l);
    logic [1:0] vd;
    logic [7:0] b;
    int         n;
    bit         hit;
    if (c == CmdEntry) begin
      if (p != 8'd255) begin
        list_chars[e][p] = v;
        if (l) list_len[e] = 9'(p) + 9'd1;
      end
      return;
    end
    if (byte_pos >= MaxPacket) begin
      pkt_bad = 1'b1;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (byte_pos < HdrLen) hdr_copy[byte_pos] = v;
          if (byte_pos >= HdrLen - 1) phase = PH_LEN;
        end
        PH_LEN: begin
          if (v == 8'd0) begin
            if (name_len == 0) pkt_bad = 1'b1;
            phase = PH_DONE;
          end else begin
            if (name_len != 0) name_push(8'h2E);
            label_left = v;
            phase = PH_LABEL;
          end
        end
        PH_LABEL: begin
          name_push(v);
          if (label_left > 0) label_left--;
          if (label_left == 0) phase = PH_LEN;
        end
        default: ;
      endcase
      byte_pos++;
    end
    if (!l) return;

    // End of packet: match the name and emit the verdict.
    if (phase != PH_DONE) pkt_bad = 1'b1;
    if (pkt_bad) begin
      vd = VerdictBad;
    end else begin
      n = (deny_count > MaxEntries) ? MaxEntries : int'(deny_count);
      hit = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        if (int'(list_len[i]) == name_len) begin
          hit = 1'b1;
          for (int k = 0; k < name_len; k++)
            if (list_chars[i][k] != name_buf[k]) hit = 1'b0;
        end
      end
      vd = hit ? VerdictDeny : VerdictAllow;
    end
    case (vd)
      VerdictDeny: n_deny++;
      VerdictBad: n_bad++;
      default: n_allow++;
    endcase
    pending_results.push_back({1'b0, verdict_forced ? forced_verdict : vd, 8'd0,
                               vd != VerdictDeny});
    if (vd == VerdictDeny) begin
      for (int k = 0; k < HdrLen; k++) begin
        b = hdr_copy[k];
        if (k == 2) b = b | 8'h80;
        else if (k == 3) b = (b & 8'hF0) | 8'h03;
        else if (k == 6 || k == 7) b = 8'h00;
        pending_results.push_back({1'b1, VerdictDeny, b, k == HdrLen - 1});
      end
    end
    name_len = 0;
    byte_pos = 0;
    label_left = 0;
    phase = PH_HEADER;
    pkt_bad = 1'b0;
  endfunction

  function automatic void name_push(logic [7:0] ch);
    if (name_len < NameLimit - 1) begin
      name_buf[name_len] = ch;
      name_len++;
    end else begin
      pkt_bad = 1'b1;
    end
  endfunction

  // Present one request and wait for it to be taken.
  task automatic send_request(logic c, logic [7:0] e, logic [7:0] p, logic [7:0] v,
                              logic l);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    entry_index <= e;
    char_pos <= p;
    value <= v;
    last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(c, e, p, v, l);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived and the matcher is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_count(logic [8:0] cnt);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    @(negedge clk);
    cfg_we <= 1'b0;
    deny_count = cnt;
  endtask

  task automatic load_entry(int e);
    for (int p = 0; p < entry_text[e].size(); p++)
      send_request(CmdEntry, 8'(e), 8'(p), entry_text[e][p], p == entry_text[e].size() - 1);
  endtask

  // Random dotted name of one to three short labels.
  function automatic void random_name(ref byte nm[$]);
    int labels;
    nm.delete();
    labels = $urandom_range(1, 3);
    for (int i = 0; i < labels; i++) begin
      if (i != 0) nm.push_back(8'h2E);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(1)) nm.push_back(byte'($urandom_range(97, 122)));
        else nm.push_back(byte'($urandom_range(65, 90)));
      end
    end
  endfunction

  // Encode a dotted name as length-prefixed labels.
  function automatic void encode_name(const ref byte nm[$], ref byte pkt[$]);
    int start;
    start = 0;
    for (int i = 0; i <= nm.size(); i++) begin
      if (i == nm.size() || nm[i] == 8'h2E) begin
        pkt.push_back(byte'(i - start));
        for (int k = start; k < i; k++) pkt.push_back(nm[k]);
        start = i + 1;
      end
    end
  endfunction

  function automatic void random_header(ref byte pkt[$]);
    int pick;
    pick = $urandom_range(9);
    for (int i = 0; i < HdrLen; i++)
      pkt.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : byte'($urandom_range(255)));
  endfunction

  // Build the bytes of one query of the given shape.
  function automatic void build_query(shape_e shape, int e, ref byte pkt[$]);
    byte nm[$];
    int  at;
    pkt.delete();
    random_header(pkt);
    case (shape)
      SH_NAME, SH_TRAIL: begin
        nm = entry_text[e];
        encode_name(nm, pkt);
        pkt.push_back(8'h00);
        if (shape == SH_TRAIL) repeat ($urandom_range(1, 6)) pkt.push_back(byte'($urandom()));
      end
      SH_FLIP: begin
        nm = entry_text[e];
        at = $urandom_range(nm.size() - 1);
        if (nm[at] == 8'h2E) at = 0;
        nm[at] = nm[at] ^ 8'h20;
        encode_name(nm, pkt);
        pkt.push_back(8'h00);
      end
      SH_SHORT: repeat ($urandom_range(1, 11)) void'(pkt.pop_back());
      SH_HDRONLY: ;
      SH_ZERO: pkt.push_back(8'h00);
      SH_UNTERM: begin
        random_name(nm);
        encode_name(nm, pkt);
        if ($urandom_range(1)) void'(pkt.pop_back());
      end
      SH_LONGNAME: begin
        pkt.push_back(8'd200);
        repeat (200) pkt.push_back(8'h61);
        pkt.push_back(8'd100);
        repeat (100) pkt.push_back(8'h62);
        pkt.push_back(8'h00);
      end
      SH_LONGPKT: begin
        pkt.push_back(8'd1);
        pkt.push_back(8'h78);
        pkt.push_back(8'h00);
        while (pkt.size() < MaxPacket + 6) pkt.push_back(byte'($urandom()));
      end
      SH_PTR: begin
        pkt.push_back(8'hC0);
        repeat (192) pkt.push_back(byte'($urandom_range(33, 126)));
        pkt.push_back(8'h00);
      end
      default: begin
        random_name(nm);
        encode_name(nm, pkt);
        pkt.push_back(8'h00);
      end
    endcase
  endfunction

  task automatic send_query(const ref byte pkt[$]);
    for (int i = 0; i < pkt.size(); i++)
      send_request(CmdPacket, 8'($urandom()), 8'($urandom()), pkt[i], i == pkt.size() - 1);
    pkts_sent++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d verdict %0d data %0h", kind,
               verdict, data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          errors++;
        end
        if (verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, verdict);
          errors++;
        end
        if (data !== want.data) begin
          $error("data: expected %0h, got %0h", want.data, data);
          errors++;
        end
        if (end_of_run !== want.eor) begin
          $error("end_of_run: expected %0d, got %0d", want.eor, end_of_run);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= quiet || $urandom_range(99) >= 17;
    end
  end

  // Watchdog on cycles with no request moving on either side.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    row_t rows[$];
    byte  pkt[$];
    int   rand_start, pick, e;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CmdEntry;
    entry_index = '0;
    char_pos = '0;
    value = '0;
    last = 1'b0;
    deny_count = '0;
    name_len = 0;
    byte_pos = 0;
    label_left = 0;
    phase = PH_HEADER;
    pkt_bad = 1'b0;
    verdict_forced = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Load sixteen named entries while nothing is counted.
    write_count(9'd0);
    for (int i = 0; i < 16; i++) begin
      random_name(entry_text[i]);
      entry_text[i].push_back(byte'(65 + i));
      load_entry(i);
    end

    rows = '{
      '{SH_NAME, 0, 1, VerdictAllow},
      '{SH_CFG, 16, 0, VerdictAllow},
      '{SH_NAME, 0, 1, VerdictDeny},
      '{SH_NAME, 15, 1, VerdictDeny},
      '{SH_FLIP, 3, 0, VerdictAllow},
      '{SH_TRAIL, 5, 1, VerdictDeny},
      '{SH_SHORT, 0, 1, VerdictBad},
      '{SH_HDRONLY, 0, 1, VerdictBad},
      '{SH_ZERO, 0, 1, VerdictBad},
      '{SH_UNTERM, 0, 1, VerdictBad},
      '{SH_LONGNAME, 0, 1, VerdictBad},
      '{SH_LONGPKT, 0, 1, VerdictBad},
      '{SH_PTR, 0, 0, VerdictAllow},
      '{SH_ENT255, 0, 0, VerdictAllow},
      '{SH_CFG, 5, 0, VerdictAllow},
      '{SH_NAME, 10, 1, VerdictAllow},
      '{SH_NAME, 4, 1, VerdictDeny}
    };
    foreach (rows[r]) begin
      case (rows[r].shape)
        SH_CFG: write_count(9'(rows[r].arg));
        SH_ENT255: begin
          // Longest entry, then a write at the ignored last position.
          send_request(CmdEntry, 8'd255, 8'd254, 8'h7A, 1'b1);
          send_request(CmdEntry, 8'd255, 8'd255, 8'hFF, 1'b1);
        end
        default: begin
          build_query(rows[r].shape, rows[r].arg, pkt);
          verdict_forced = rows[r].typed;
          forced_verdict = rows[r].want;
          send_query(pkt);
          verdict_forced = 1'b0;
        end
      endcase
    end

    // Random queries, with setting changes between phases.
    write_count(9'd16);
    rand_start = items_sent;
    for (int q = 0; items_sent - rand_start < 380 || q < 70; q++) begin
      if (q == 10) hold_req = 1'b1;
      if (q == 20) begin
        // Give every entry a defined length so the full count is legal.
        drain();
        for (int i = 16; i < MaxEntries; i++) begin
          entry_text[i].delete();
          entry_text[i].push_back(byte'($urandom_range(97, 122)));
          load_entry(i);
        end
        write_count(9'd256);
      end
      if (q == 28) begin
        // Noise writes past every entry's length leave matching intact.
        drain();
        repeat (20)
          send_request(CmdEntry, 8'($urandom()), 8'($urandom_range(16, 255)),
                       8'($urandom()), 1'b0);
      end
      if (q == 30) quiet = 1'b1;
      if (q == 45) quiet = 1'b0;
      if (q == 40) write_count(9'd255);
      if (q == 55) write_count(9'd3);
      if (q == 62) write_count(9'd256);
      pick = $urandom_range(99);
      e = $urandom_range(deny_count > 16 ? 16 : (deny_count == 0 ? 1 : deny_count) - 1);
      if ($urandom_range(3) == 0) e = $urandom_range(MaxEntries - 1);
      if (entry_text[e].size() == 0) e = 0;
      if (pick < 40) build_query(SH_NAME, e, pkt);
      else if (pick < 50) build_query(SH_TRAIL, e, pkt);
      else if (pick < 58) build_query(SH_FLIP, e, pkt);
      else if (pick < 75) build_query(SH_CFG, 0, pkt);
      else if (pick < 81) build_query(SH_SHORT, 0, pkt);
      else if (pick < 86) build_query(SH_ZERO, 0, pkt);
      else if (pick < 93) build_query(SH_UNTERM, 0, pkt);
      else if (pick < 96) build_query(SH_HDRONLY, 0, pkt);
      else build_query(SH_PTR, 0, pkt);
      send_query(pkt);
    end

    // Wrap up.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d requests in %0d queries: %0d allowed, %0d denied, %0d malformed.",
             items_sent, pkts_sent, n_allow, n_deny, n_bad);
    $display("Checked %0d results across deny counts 0 to 256 with stalls and hold-off.",
             results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
